>>> sv/rfpq_pkg.sv
// shared widths, codes and controller/datapath interface types
package rfpq_pkg;

	localparam int unsigned IDX_W            = 11;
	localparam int unsigned POS_W            = IDX_W + 1;
	localparam int unsigned MAX_ELEMENTS_DEF = 1024;
	localparam logic [IDX_W-1:0] LEN_RESET   = 11'd1024;

	localparam logic ACT_FLIP  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic load_b;
		logic step_up;
		logic step_down;
		logic out_load;
	} rfpq_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic req_query;
		logic up_end;
		logic down_end;
	} rfpq_status_t;

endpackage

>>> sv/range_flip_point_query_bit_tree_core.sv
// flip: an upward tree walk from the first mark, then one from the mark after the last index
// query: a downward tree walk from the first index, then the parity result is registered
// one tree memory access per step bounds throughput; a new request is taken only when the last is done
// reset: length 1024, then a clearing pass over tree entries 0 to MAX_ELEMENTS before requests
// the length register takes writes during the clearing pass as at any other time
module range_flip_point_query_bit_tree_core #(
	parameter int unsigned MAX_ELEMENTS = rfpq_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rfpq_pkg::IDX_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [rfpq_pkg::IDX_W-1:0]  first_index,
	input  logic [rfpq_pkg::IDX_W-1:0]  last_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        element_value
);
	import rfpq_pkg::*;

	rfpq_cmd_t    cmd;
	rfpq_status_t status;

	rfpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rfpq_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.action        (action),
		.first_index   (first_index),
		.last_index    (last_index),
		.cmd           (cmd),
		.status        (status),
		.element_value (element_value)
	);

endmodule

>>> sv/rfpq_dp.sv
// datapath: length register, parity tree memory, walk position and prefix parity
module rfpq_dp #(
	parameter int unsigned MAX_ELEMENTS = rfpq_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [rfpq_pkg::IDX_W-1:0]   cfg_wr_data,
	input  logic                         action,
	input  logic [rfpq_pkg::IDX_W-1:0]   first_index,
	input  logic [rfpq_pkg::IDX_W-1:0]   last_index,
	input  rfpq_pkg::rfpq_cmd_t          cmd,
	output rfpq_pkg::rfpq_status_t       status,
	output logic                         element_value
);
	import rfpq_pkg::*;

	localparam int unsigned DEPTH = MAX_ELEMENTS + 1;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic mem [DEPTH];

	logic [IDX_W-1:0] len_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] used_len;
	logic [IDX_W-1:0] first_f;
	logic [IDX_W-1:0] last_c;
	logic             flip_do;
	logic             query_ok;
	logic [POS_W-1:0] start_pos;
	logic [POS_W-1:0] b_start;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] b_pos_q;
	logic [POS_W-1:0] low_bit;
	logic             up_ok;
	logic [AW-1:0]    rd_addr;
	logic             rd_q;
	logic             tog_s1;
	logic             qv_s1;
	logic [AW-1:0]    addr_s1;
	logic [AW-1:0]    clr_cnt_q;
	logic             acc_q;
	logic             elem_q;

	// effective length, range clipping and start points of the walks
	always_comb begin
		used_len = (32'(len_q) > MAX_ELEMENTS) ? IDX_W'(MAX_ELEMENTS) : len_q;
		first_f  = (first_index == '0) ? IDX_W'(1) : first_index;
		last_c   = (last_index > used_len) ? used_len : last_index;
		flip_do  = (first_f <= last_c);
		query_ok = (first_index != '0) && (first_index <= used_len);
		if (action == ACT_QUERY) begin
			start_pos = query_ok ? {1'b0, first_index} : '0;
		end else begin
			start_pos = flip_do ? {1'b0, first_f} : '0;
		end
		b_start = flip_do ? (POS_W'(last_c) + POS_W'(1)) : '0;
	end

	assign low_bit = pos_q & (~pos_q + POS_W'(1));
	assign up_ok   = (pos_q != '0) && (pos_q <= {1'b0, n_q});
	assign rd_addr = AW'(pos_q);

	assign status.clear_last = (clr_cnt_q == AW'(MAX_ELEMENTS));
	assign status.req_query  = (action == ACT_QUERY);
	assign status.up_end     = !up_ok;
	assign status.down_end   = (pos_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= LEN_RESET;
			clr_cnt_q <= '0;
			tog_s1    <= 1'b0;
			qv_s1     <= 1'b0;
			pos_q     <= '0;
			b_pos_q   <= '0;
			n_q       <= '0;
			acc_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				len_q <= cfg_wr_data;
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			tog_s1 <= cmd.step_up && up_ok;
			qv_s1  <= cmd.step_down && (pos_q != '0);
			if (cmd.accept) begin
				pos_q   <= start_pos;
				b_pos_q <= b_start;
				n_q     <= used_len;
			end else if (cmd.load_b) begin
				pos_q <= b_pos_q;
			end else if (cmd.step_up && up_ok) begin
				pos_q <= pos_q + low_bit;
			end else if (cmd.step_down && (pos_q != '0)) begin
				pos_q <= pos_q - low_bit;
			end
			if (cmd.accept) begin
				acc_q <= 1'b0;
			end else if (qv_s1) begin
				acc_q <= acc_q ^ rd_q;
			end
		end
	end

	// tree memory: one write and one registered read per cycle, new data forwarded
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_cnt_q] <= 1'b0;
		end else if (tog_s1) begin
			mem[addr_s1] <= ~rd_q;
		end
		rd_q    <= (tog_s1 && (addr_s1 == rd_addr)) ? ~rd_q : mem[rd_addr];
		addr_s1 <= rd_addr;
		if (cmd.out_load) begin
			elem_q <= acc_q;
		end
	end

	assign element_value = elem_q;

endmodule

>>> sv/rfpq_ctrl.sv
// controller: clearing pass, flip walks, query walk and result handshake
module rfpq_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  rfpq_pkg::rfpq_status_t  status,
	output rfpq_pkg::rfpq_cmd_t     cmd
);
	import rfpq_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FLIP_A,
		ST_FLIP_B,
		ST_QUERY,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd           = '0;
		in_ready      = (state_q == ST_IDLE);
		cmd.clr_step  = (state_q == ST_CLEAR);
		cmd.accept    = in_ready && in_valid;
		cmd.step_up   = (state_q == ST_FLIP_A) || (state_q == ST_FLIP_B);
		cmd.load_b    = (state_q == ST_FLIP_A) && status.up_end;
		cmd.step_down = (state_q == ST_QUERY);
		cmd.out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (status.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= status.req_query ? ST_QUERY : ST_FLIP_A;
					end
				end
				ST_FLIP_A: begin
					if (status.up_end) begin
						state_q <= ST_FLIP_B;
					end
				end
				ST_FLIP_B: begin
					if (status.up_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QUERY: begin
					if (status.down_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
